// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the erfcx core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/scfe_pkg.sv -----
// Package: constants, types and fixed-point helpers of the erfcx core.
`timescale 1ns / 1ps
package scfe_pkg;

   localparam int COEFF_COUNT      = 28;
   localparam int INPUT_FRAC_BITS  = 24;
   localparam int OUTPUT_FRAC_BITS = 30;

   localparam int ARG_W        = 32;
   localparam int VAL_W        = 32;
   localparam int FRAC         = 40;
   localparam int DW           = 48;
   localparam int HALF         = DW / 2;
   localparam int PROD_W       = 2 * DW + 1;
   localparam int TAYLOR_TERMS = 11;

   // divider: one quotient bit per stage
   localparam int DIV_STEPS = FRAC + 1;
   localparam int DEN_W     = ARG_W + 1;
   localparam int REM_W     = DEN_W + 1;
   localparam int T_W       = FRAC + 1;
   localparam int CL_STEPS  = COEFF_COUNT - 1;
   localparam int OUT_SHIFT = FRAC - OUTPUT_FRAC_BITS;

   // reciprocal multiply for the Horner divisions by k
   localparam int MAG_W       = DW - 1;
   localparam int RCP_W       = 52;
   localparam int RCP_SUM_W   = 2 * RCP_W - 4;
   localparam int RECIP_SHIFT = 51;

   localparam int LATENCY = DIV_STEPS + 1 + 2 * CL_STEPS + 3 + 4 * TAYLOR_TERMS + 5;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

   typedef logic signed [DW-1:0] fx_type;

   localparam longint FX_ONE_L = 64'sd1 <<< FRAC;
   localparam longint FX_MAX_L = (64'sd1 <<< (DW - 1)) - 64'sd1;
   localparam longint FX_MIN_L = -(64'sd1 <<< (DW - 1));
   localparam fx_type FX_ONE   = fx_type'(FX_ONE_L);
   localparam logic [DEN_W-1:0] DIV_NUM = DEN_W'(64'd2 << INPUT_FRAC_BITS);
   localparam longint VAL_LIM  = 64'sd1 <<< OUTPUT_FRAC_BITS;

   // Chebyshev coefficients in Q.40
   localparam longint CHEB [28] = '{
      -64'sd1432282911866, 64'sd705853251377, 64'sd21414608756, -64'sd10512996687,
      -64'sd1040792588, 64'sd403344293, 64'sd46754890, -64'sd22296532,
      -64'sd1785926, 64'sd1433385, 64'sd17181, -64'sd93720,
      64'sd7179, 64'sd5563, -64'sd1090, -64'sd250,
      64'sd106, 64'sd3, -64'sd8, 64'sd1,
      64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
   };

   // exp(-1.5), exp(-0.5), exp(0.5) in Q.40
   localparam longint EXP_MID [3] = '{
      64'sd245334205591, 64'sd666887512957, 64'sd1812788208096
   };

   // ceil(2^51 / k), index k
   localparam longint RECIP [TAYLOR_TERMS+1] = '{
      64'sd0, 64'sd2251799813685248, 64'sd1125899906842624, 64'sd750599937895083,
      64'sd562949953421312, 64'sd450359962737050, 64'sd375299968947542,
      64'sd321685687669322, 64'sd281474976710656, 64'sd250199979298361,
      64'sd225179981368525, 64'sd204709073971387
   };

   typedef struct packed {
      logic neg;
      logic refused;
   } tag_type;

   typedef struct packed {
      tag_type           tag;
      logic [ARG_W-1:0]  mag;
   } front_type;

   typedef struct packed {
      tag_type           tag;
      logic [DEN_W-1:0]  den;
      logic [REM_W-1:0]  rem;
      logic [T_W-1:0]    quo;
   } div_type;

   typedef struct packed {
      logic          sgn;
      logic [DW-1:0] hh;
      logic [DW-1:0] hl;
      logic [DW-1:0] lh;
      logic [DW-1:0] ll;
   } pp_type;

   typedef struct packed {
      logic             sgn;
      logic [RCP_W-1:0] hh;
      logic [RCP_W-1:0] hl;
      logic [RCP_W-1:0] lh;
      logic [RCP_W-1:0] ll;
   } rp_type;

   typedef struct packed {
      tag_type        tag;
      logic [T_W-1:0] t;
      fx_type         ty;
      fx_type         d;
      fx_type         dd;
      pp_type         pp;
   } cl_type;

   typedef struct packed {
      tag_type          tag;
      logic [T_W-1:0]   t;
      logic [1:0]       idx;
      fx_type           g;
      fx_type           p;
      logic [MAG_W-1:0] mag;
      logic             sgn;
      pp_type           pp;
      rp_type           rp;
   } ex_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    status;
   } out_type;

   function automatic fx_type sat48(input logic signed [63:0] v);
      if (v > FX_MAX_L) return fx_type'(FX_MAX_L);
      if (v < FX_MIN_L) return fx_type'(FX_MIN_L);
      return fx_type'(v);
   endfunction

   // first half of a Q.40 product: four 24x24 partial products of the magnitudes
   function automatic pp_type fmul_pp(input fx_type a, input fx_type b);
      pp_type        r;
      logic [DW-1:0] ua;
      logic [DW-1:0] ub;
      ua = a[DW-1] ? (~a + 48'd1) : a;
      ub = b[DW-1] ? (~b + 48'd1) : b;
      r.sgn = a[DW-1] ^ b[DW-1];
      r.hh  = DW'(ua[DW-1:HALF]) * DW'(ub[DW-1:HALF]);
      r.hl  = DW'(ua[DW-1:HALF]) * DW'(ub[HALF-1:0]);
      r.lh  = DW'(ua[HALF-1:0]) * DW'(ub[DW-1:HALF]);
      r.ll  = DW'(ua[HALF-1:0]) * DW'(ub[HALF-1:0]);
      return r;
   endfunction

   // second half: sum, round half away from zero, apply sign
   function automatic logic signed [63:0] fmul_sum(input pp_type p);
      logic [PROD_W-1:0] s;
      logic [63:0]       q;
      s = (PROD_W'(p.hh) << (2 * HALF)) + (PROD_W'(p.hl) << HALF)
        + (PROD_W'(p.lh) << HALF) + PROD_W'(p.ll) + (PROD_W'(1) << (FRAC - 1));
      q = 64'(s >> FRAC);
      return p.sgn ? -$signed(q) : $signed(q);
   endfunction

   function automatic rp_type rcp_pp(input logic [MAG_W-1:0] m, input logic [RCP_W-1:0] r,
                                     input logic sgn);
      rp_type o;
      o.sgn = sgn;
      o.hh  = RCP_W'(m[MAG_W-1:HALF]) * RCP_W'(r[RCP_W-1:HALF]);
      o.hl  = RCP_W'(m[MAG_W-1:HALF]) * RCP_W'(r[HALF-1:0]);
      o.lh  = RCP_W'(m[HALF-1:0]) * RCP_W'(r[RCP_W-1:HALF]);
      o.ll  = RCP_W'(m[HALF-1:0]) * RCP_W'(r[HALF-1:0]);
      return o;
   endfunction

   // floor(m / k) from the reciprocal partial products
   function automatic logic [MAG_W-1:0] rcp_sum(input rp_type p);
      logic [RCP_SUM_W-1:0] s;
      s = (RCP_SUM_W'(p.hh) << (2 * HALF)) + (RCP_SUM_W'(p.hl) << HALF)
        + (RCP_SUM_W'(p.lh) << HALF) + RCP_SUM_W'(p.ll);
      return MAG_W'(s >> RECIP_SHIFT);
   endfunction

   function automatic fx_type exp_mid(input logic [1:0] idx);
      case (idx)
         2'd0:    return fx_type'(EXP_MID[0]);
         2'd1:    return fx_type'(EXP_MID[1]);
         default: return fx_type'(EXP_MID[2]);
      endcase
   endfunction

endpackage

// ----- rtl/scfe_if.sv -----
// Channel interfaces: argument words in, result words out.
`timescale 1ns / 1ps
interface scfe_req_if;
   import scfe_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [ARG_W-1:0] argument;
   logic                    odd_extension;
   modport source (output valid, argument, odd_extension, input ready);
   modport sink   (input valid, argument, odd_extension, output ready);
endinterface

interface scfe_rsp_if;
   import scfe_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   logic                    status;
   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

// ----- rtl/scfe_front.sv -----
// Front end: takes argument words, splits sign and magnitude, feeds the queue.
`timescale 1ns / 1ps
module scfe_front (
   input  logic                 clock,
   input  logic                 reset,
   scfe_req_if.sink             req_port,
   input  logic                 q_full,
   output logic                 q_push,
   output scfe_pkg::front_type  q_word
);
   import scfe_pkg::*;

   logic      hold_v_ff, hold_v_in;
   front_type hold_ff, hold_in;
   front_type cls;
   logic      accept;

   // classify: sign, refusal, exact magnitude (2^31 for the most negative word)
   always_comb begin
      cls.tag.neg     = req_port.argument[ARG_W-1];
      cls.tag.refused = req_port.argument[ARG_W-1] & ~req_port.odd_extension;
      cls.mag         = req_port.argument[ARG_W-1] ? (~req_port.argument + 32'd1)
                                                   : req_port.argument;
   end

   assign q_push         = hold_v_ff & ~q_full;
   assign req_port.ready = ~hold_v_ff | ~q_full;
   assign accept         = req_port.valid & req_port.ready;
   assign q_word         = hold_ff;

   always_comb begin
      hold_v_in = accept | (hold_v_ff & ~q_push);
      hold_in   = accept ? cls : hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
      end
      hold_ff <= hold_in;
   end

endmodule

// ----- rtl/scfe_fifo.sv -----
// Short queue between the front end and the arithmetic pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scfe_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  scfe_pkg::front_type  push_word,
   output logic                 full,
   input  logic                 pop,
   output scfe_pkg::front_type  head,
   output logic                 empty
);
   import scfe_pkg::*;

   front_type        slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   assign full  = (lvl_ff == LVL_W'(FIFO_DEPTH));
   assign empty = (lvl_ff == '0);
   assign head  = slot_ff[rd_ff];

   // pointer and level update
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      lvl_in = lvl_ff + LVL_W'(push) - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         lvl_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         lvl_ff <= lvl_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_word;
      end
   end

   `ASSERT_ALWAYS(a_lvl_range, lvl_ff <= LVL_W'(FIFO_DEPTH), "queue level out of range")
   `ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "pop from empty queue")
   `ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")

endmodule

// ----- rtl/scfe_back.sv -----
// Back end: divider, Clenshaw recurrence, exponential and output rounding.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scfe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  scfe_pkg::front_type  head,
   input  logic                 empty,
   output logic                 pop,
   scfe_rsp_if.source           rsp_port
);
   import scfe_pkg::*;

   logic [LATENCY-1:0] vld_ff, vld_in;
   logic               adv;

   div_type div_init;
   div_type div_src [DIV_STEPS];
   div_type div_in  [DIV_STEPS];
   div_type div_ff  [DIV_STEPS];

   cl_type  prep_in, prep_ff;
   cl_type  cla_src [CL_STEPS];
   cl_type  cla_in  [CL_STEPS];
   cl_type  cla_ff  [CL_STEPS];
   cl_type  clb_in  [CL_STEPS];
   cl_type  clb_ff  [CL_STEPS];
   cl_type  fa_in, fa_ff, fb_in, fb_ff;

   ex_type  fc_in, fc_ff;
   ex_type  exa_src [TAYLOR_TERMS];
   ex_type  exa_in  [TAYLOR_TERMS];
   ex_type  exa_ff  [TAYLOR_TERMS];
   ex_type  exb_in  [TAYLOR_TERMS];
   ex_type  exb_ff  [TAYLOR_TERMS];
   ex_type  exc_in  [TAYLOR_TERMS];
   ex_type  exc_ff  [TAYLOR_TERMS];
   ex_type  exd_in  [TAYLOR_TERMS];
   ex_type  exd_ff  [TAYLOR_TERMS];
   ex_type  ea_in, ea_ff, eb_in, eb_ff, ta_in, ta_ff, tb_in, tb_ff;
   out_type out_in, out_ff;

   // whole pipeline moves when the output word is free or being taken
   assign adv = ~vld_ff[LATENCY-1] | rsp_port.ready;
   assign pop = adv & ~empty;
   assign vld_in = {vld_ff[LATENCY-2:0], pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // divider entry: t = num / (num + a)
   always_comb begin
      div_init.tag = head.tag;
      div_init.den = DIV_NUM + DEN_W'(head.mag);
      div_init.rem = REM_W'(DIV_NUM);
      div_init.quo = '0;
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      if (j == 0) begin : g_first
         assign div_src[j] = div_init;
      end else begin : g_next
         assign div_src[j] = div_ff[j-1];
      end
      always_comb begin
         logic [REM_W-1:0] r2;
         logic [T_W-1:0]   q2;
         r2 = (j == 0) ? div_src[j].rem : {div_src[j].rem[REM_W-2:0], 1'b0};
         q2 = (j == 0) ? div_src[j].quo : {div_src[j].quo[T_W-2:0], 1'b0};
         if (r2 >= REM_W'(div_src[j].den)) begin
            r2    = r2 - REM_W'(div_src[j].den);
            q2[0] = 1'b1;
         end
         div_in[j]     = div_src[j];
         div_in[j].rem = r2;
         div_in[j].quo = q2;
      end
      always_ff @(posedge clock) begin
         if (adv) div_ff[j] <= div_in[j];
      end
   end

   // ty = 4t - 2, recurrence state cleared
   always_comb begin
      prep_in     = '0;
      prep_in.tag = div_ff[DIV_STEPS-1].tag;
      prep_in.t   = div_ff[DIV_STEPS-1].quo;
      prep_in.ty  = fx_type'(DW'({div_ff[DIV_STEPS-1].quo, 2'b00})) - (FX_ONE <<< 1);
   end

   always_ff @(posedge clock) begin
      if (adv) prep_ff <= prep_in;
   end

   // Clenshaw: product stage, then combine stage
   for (genvar s = 0; s < CL_STEPS; s++) begin : g_cl
      if (s == 0) begin : g_first
         assign cla_src[s] = prep_ff;
      end else begin : g_next
         assign cla_src[s] = clb_ff[s-1];
      end
      always_comb begin
         cla_in[s]    = cla_src[s];
         cla_in[s].pp = fmul_pp(cla_src[s].ty, cla_src[s].d);
      end
      always_comb begin
         clb_in[s]    = cla_ff[s];
         clb_in[s].d  = sat48(fmul_sum(cla_ff[s].pp) - 64'(cla_ff[s].dd)
                              + CHEB[COEFF_COUNT-1-s]);
         clb_in[s].dd = cla_ff[s].d;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cla_ff[s] <= cla_in[s];
            clb_ff[s] <= clb_in[s];
         end
      end
   end

   // s = c0 + ty*d (kept in d)
   always_comb begin
      fa_in    = clb_ff[CL_STEPS-1];
      fa_in.pp = fmul_pp(fa_in.ty, fa_in.d);
      fb_in    = fa_ff;
      fb_in.d  = sat48(CHEB[0] + fmul_sum(fa_ff.pp));
   end

   // exponent argument s/2 - dd, clamped, split into table index and offset
   always_comb begin
      logic signed [63:0] hs;
      logic signed [63:0] a2;
      logic signed [63:0] u;
      hs = 64'(fb_ff.d) + 64'(fb_ff.d[DW-1]);
      hs = hs >>> 1;
      a2 = 64'(sat48(hs - 64'(fb_ff.dd)));
      if (a2 < -(FX_ONE_L <<< 1)) a2 = -(FX_ONE_L <<< 1);
      if (a2 > FX_ONE_L - 64'sd1) a2 = FX_ONE_L - 64'sd1;
      u = a2 + (FX_ONE_L <<< 1);
      fc_in     = '0;
      fc_in.tag = fb_ff.tag;
      fc_in.t   = fb_ff.t;
      fc_in.idx = u[FRAC+1:FRAC];
      fc_in.g   = fx_type'(DW'(u[FRAC-1:0])) - (FX_ONE >>> 1);
      fc_in.p   = FX_ONE;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fa_ff <= fa_in;
         fb_ff <= fb_in;
         fc_ff <= fc_in;
      end
   end

   // Horner steps: p = 1 + (g*p)/k, k from TAYLOR_TERMS down to 1
   for (genvar h = 0; h < TAYLOR_TERMS; h++) begin : g_exp
      if (h == 0) begin : g_first
         assign exa_src[h] = fc_ff;
      end else begin : g_next
         assign exa_src[h] = exd_ff[h-1];
      end
      always_comb begin
         logic signed [63:0] prod;
         logic signed [63:0] qs;
         exa_in[h]    = exa_src[h];
         exa_in[h].pp = fmul_pp(exa_src[h].g, exa_src[h].p);
         prod          = fmul_sum(exa_ff[h].pp);
         exb_in[h]     = exa_ff[h];
         exb_in[h].sgn = prod[63];
         exb_in[h].mag = MAG_W'(prod[63] ? -prod : prod);
         exc_in[h]     = exb_ff[h];
         exc_in[h].rp  = rcp_pp(exb_ff[h].mag, RCP_W'(RECIP[TAYLOR_TERMS-h]), exb_ff[h].sgn);
         qs            = $signed(64'(rcp_sum(exc_ff[h].rp)));
         exd_in[h]     = exc_ff[h];
         exd_in[h].p   = sat48(FX_ONE_L + (exc_ff[h].rp.sgn ? -qs : qs));
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            exa_ff[h] <= exa_in[h];
            exb_ff[h] <= exb_in[h];
            exc_ff[h] <= exc_in[h];
            exd_ff[h] <= exd_in[h];
         end
      end
   end

   // e = exp_mid * p, then result = t * e
   always_comb begin
      ea_in    = exd_ff[TAYLOR_TERMS-1];
      ea_in.pp = fmul_pp(exp_mid(ea_in.idx), ea_in.p);
      eb_in    = ea_ff;
      eb_in.p  = sat48(fmul_sum(ea_ff.pp));
      ta_in    = eb_ff;
      ta_in.pp = fmul_pp(fx_type'(DW'(eb_ff.t)), eb_ff.p);
      tb_in    = ta_ff;
      tb_in.p  = sat48(fmul_sum(ta_ff.pp));
   end

   // round to output format, clamp to one, apply odd extension or refusal
   always_comb begin
      logic signed [63:0] rnd;
      rnd = tb_ff.p[DW-1] ? 64'sd0 : 64'(tb_ff.p);
      rnd = (rnd + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (rnd > VAL_LIM) rnd = VAL_LIM;
      if (tb_ff.tag.neg) rnd = -rnd;
      out_in.value  = tb_ff.tag.refused ? '0 : VAL_W'(rnd);
      out_in.status = tb_ff.tag.refused;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ea_ff  <= ea_in;
         eb_ff  <= eb_in;
         ta_ff  <= ta_in;
         tb_ff  <= tb_in;
         out_ff <= out_in;
      end
   end

   assign rsp_port.valid  = vld_ff[LATENCY-1];
   assign rsp_port.value  = out_ff.value;
   assign rsp_port.status = out_ff.status;

   `ASSERT_IMPLIES(a_refused_zero, rsp_port.valid && rsp_port.status, rsp_port.value == '0, "refused word carries nonzero value")
   `ASSERT_IMPLIES(a_value_range, rsp_port.valid, (rsp_port.value <= VAL_LIM) && (rsp_port.value >= -VAL_LIM), "result magnitude above one")
   `ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld_ff), "pipeline moved while stalled")

endmodule

// ----- rtl/scaled_complementary_error_function_core.sv -----
// Path from argument word accepted to result word valid: the front register, the queue,
// then 148 arithmetic stages (41 divider bits, 27 Clenshaw steps of two stages,
// 11 Horner steps of four stages, final products and rounding); the last stage holds
// the result word.
// Throughput: one word per cycle; a stalled result freezes the whole arithmetic pipeline
// while the four-word queue and front register keep taking words until they are full.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
`timescale 1ns / 1ps
module scaled_complementary_error_function_core (
   input  logic        clock,
   input  logic        reset,
   scfe_req_if.sink    req_port,
   scfe_rsp_if.source  rsp_port
);
   import scfe_pkg::*;

   logic      q_push, q_full, q_pop, q_empty;
   front_type q_word, q_head;

   scfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_word   (q_word)
   );

   scfe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_word),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   scfe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp_port (rsp_port)
   );

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench of the erfcx core: directed and random arguments checked against a fixed-point predictor.
`timescale 1ns / 1ps
module testbench;
   import scfe_pkg::*;

   localparam int     WATCHDOG_LIMIT = 5000;
   localparam int     LONG_HOLD      = 400;
   localparam longint Q_ONE          = 64'sd1 <<< 40;
   localparam longint Q_MAX          = (64'sd1 <<< 47) - 64'sd1;
   localparam longint Q_MIN          = -(64'sd1 <<< 47);

   logic clock;
   logic reset;

   scfe_req_if req_port ();
   scfe_rsp_if rsp_port ();

   scaled_complementary_error_function_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port.sink),
      .rsp_port (rsp_port.source)
   );

   // pending result words, oldest first
   out_type erfcx_pending [$];
   bit      failed;
   int      idle_cycles;
   int      hold_request;
   int      ready_stall_pct;
   int      send_gap_pct;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --- fixed-point predictor, Q8.40 in 64-bit containers ---
   function automatic longint clip48(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // product rounded to nearest, halves away from zero
   function automatic longint qmul(input longint a, input longint b);
      longint unsigned ua, ub, ah, al, bh, bl, mid, low, q;
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      ah  = ua >> 24;
      al  = ua & 64'hFFFFFF;
      bh  = ub >> 24;
      bl  = ub & 64'hFFFFFF;
      mid = ah * bl + al * bh;
      low = ((mid & 64'hFFFF) << 24) + al * bl + (64'd1 << 39);
      q   = ((ah * bh) << 8) + (mid >> 16) + (low >> 40);
      return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint qexp(input longint x);
      longint unsigned u;
      longint          g, p, idx;
      if (x < -2 * Q_ONE) x = -2 * Q_ONE;
      if (x > Q_ONE - 1) x = Q_ONE - 1;
      u   = x + 2 * Q_ONE;
      idx = u >> 40;
      if (idx > 2) idx = 2;
      g = longint'(u & (Q_ONE - 1)) - Q_ONE / 2;
      p = Q_ONE;
      for (int k = TAYLOR_TERMS; k >= 1; k--)
         p = clip48(Q_ONE + qmul(g, p) / k);
      return clip48(qmul(EXP_MID[idx], p));
   endfunction

   // erfcx of a non-negative magnitude in Q.40
   function automatic longint erfcx_of_mag(input longint unsigned a);
      longint unsigned num, den, r, q;
      longint          t, ty, d, dd, prev, s, x;
      num = 64'd2 << INPUT_FRAC_BITS;
      den = num + a;
      r   = num;
      q   = 0;
      d   = 0;
      dd  = 0;
      if (r >= den) begin
         r = r - den;
         q = 1;
      end
      for (int i = 0; i < 40; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      t  = q;
      ty = 4 * t - 2 * Q_ONE;
      for (int i = COEFF_COUNT - 1; i > 0; i--) begin
         prev = d;
         d    = clip48(qmul(ty, d) - dd + CHEB[i]);
         dd   = prev;
      end
      s = clip48(CHEB[0] + qmul(ty, d));
      x = clip48(s / 2 - dd);
      return clip48(qmul(t, qexp(x)));
   endfunction

   function automatic out_type erfcx_expected(input logic [31:0] arg, input logic odd);
      out_type         o;
      longint unsigned a;
      longint          res;
      o.value  = '0;
      o.status = 1'b0;
      if (arg[31] && !odd) begin
         o.status = 1'b1;
         return o;
      end
      a   = arg[31] ? (64'd1 << 32) - {32'd0, arg} : {32'd0, arg};
      res = erfcx_of_mag(a);
      if (res < 0) res = 0;
      res = (res + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (res > VAL_LIM) res = VAL_LIM;
      if (arg[31]) res = -res;
      o.value = res[31:0];
      return o;
   endfunction

   // --- send one argument word; gap after it chosen at random ---
   task automatic send_argument(input logic [31:0] arg, input logic odd);
      int gap;
      req_port.valid         <= 1'b1;
      req_port.argument      <= arg;
      req_port.odd_extension <= odd;
      @(posedge clock);
      while (!req_port.ready) @(posedge clock);
      erfcx_pending.push_back(erfcx_expected(arg, odd));
      gap = 0;
      if ($urandom_range(0, 99) < send_gap_pct)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_port.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (erfcx_pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_argument();
      logic [31:0] v;
      v = $urandom();
      // mostly magnitudes of modest size, where the curve bends
      case ($urandom_range(0, 3))
         0:       return v;
         1:       return $signed(v) >>> $urandom_range(0, 31);
         default: return $signed(v) >>> $urandom_range(4, 12);
      endcase
   endfunction

   // --- tests ---
   task automatic test_directed();
      logic [31:0] args [12];
      args = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h0000_0001, 32'h0100_0000, 32'hFF00_0000, 32'h0080_0000,
               32'h0A00_0000, 32'hF600_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (args[i]) begin
         send_argument(args[i], 1'b1);
         send_argument(args[i], 1'b0);
      end
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) begin
            ready_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            send_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         end
         send_argument(random_argument(), 1'($urandom_range(0, 1)));
      end
   endtask

   // receiver holds off while words keep coming, so the input stalls
   task automatic test_backpressure();
      send_gap_pct = 0;
      hold_request = LONG_HOLD;
      for (int i = 0; i < 250; i++)
         send_argument(random_argument(), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_pause_until_drained();
      req_port.valid <= 1'b0;
      wait_drained();
      @(posedge clock);
      test_random(20);
   endtask

   // --- main sequence ---
   initial begin
      failed                 = 1'b0;
      hold_request           = 0;
      ready_stall_pct        = 20;
      send_gap_pct           = 20;
      reset                  = 1'b1;
      req_port.valid         = 1'b0;
      req_port.argument      = '0;
      req_port.odd_extension = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(700);
      test_backpressure();
      test_pause_until_drained();
      test_random(650);
      req_port.valid <= 1'b0;
      wait_drained();
      repeat (LATENCY + 50) @(posedge clock);
      if (!failed && erfcx_pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // --- result side: random ready, long holds on request ---
   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_port.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end else if (hold_left == 0 && $urandom_range(0, 199) == 0) begin
            hold_left = $urandom_range(15, 60);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_port.ready <= 1'b0;
         end else begin
            rsp_port.ready <= ($urandom_range(0, 99) >= ready_stall_pct);
         end
      end
   end

   // --- result checker and watchdog ---
   initial begin
      out_type want;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && req_port.valid && req_port.ready)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (!reset && rsp_port.valid && rsp_port.ready) begin
            idle_cycles = 0;
            if (erfcx_pending.size() == 0) begin
               $error("result word with nothing expected: value %0d status %0d",
                      rsp_port.value, rsp_port.status);
               failed = 1'b1;
            end else begin
               want = erfcx_pending.pop_front();
               if (rsp_port.value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_port.value);
                  failed = 1'b1;
               end
               if (rsp_port.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_port.status);
                  failed = 1'b1;
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule
